### hdl/bloch_hamiltonian_eval_macros.svh
// Assertion macros for the Bloch Hamiltonian evaluator.
// Used by the files that check their own logic; needs clk and rst_n in scope.
`ifndef BLOCH_HAMILTONIAN_EVAL_MACROS_SVH
`define BLOCH_HAMILTONIAN_EVAL_MACROS_SVH
// check sampled on clk, held off while reset is active
`define BHE_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that holds in and out of reset
`define BHE_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hdl/bhe_pkg.sv
// Shared types, codes and constants of the Bloch Hamiltonian evaluator.
// No dependencies; used by bhe_phase, bhe_lane and bloch_hamiltonian_eval.
`default_nettype none
package bhe_pkg;

  localparam int DEF_MAX_TERMS = 64;
  localparam int DEF_MAX_DIMS  = 3;
  localparam int DEF_MAX_DOF   = 8;
  localparam int CORDIC_STEPS  = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam int TERM_W = 11;

  // request kinds
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EVAL  = 2'd2
  } kind_t;

  // register indexes
  typedef enum logic [1:0] {
    REG_TERMS = 2'd0,
    REG_DIMS  = 2'd1,
    REG_DOF   = 2'd2
  } reg_idx_t;

  // cosine / sine pair, Q2.30
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } cs_t;

  // matrix entry load towards the lanes
  typedef struct packed {
    logic              wr;
    logic [TERM_W-1:0] term;
    logic [2:0]        row;
    logic [2:0]        col;
    logic [23:0]       re;
    logic [23:0]       im;
  } ld_t;

  // multiply-accumulate control towards the lanes
  typedef struct packed {
    logic              clear;
    logic              issue;
    logic [TERM_W-1:0] term;
    logic [2:0]        row;
  } mac_ctl_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn(input logic [4:0] step);
    logic signed [31:0] v;
    case (step)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/bhe_phase.sv
// Phase unit: k.R dot product one axis a cycle, then an iterative CORDIC.
// Depends on bhe_pkg and bloch_hamiltonian_eval_macros.svh.
`default_nettype none
`include "bloch_hamiltonian_eval_macros.svh"
module bhe_phase #(
  parameter int MAX_DIMS = bhe_pkg::DEF_MAX_DIMS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [2:0][31:0]          k_pt,
  input  wire logic [MAX_DIMS-1:0][15:0] key,
  input  wire logic [1:0]                nd,
  output logic                           done,
  output bhe_pkg::cs_t                   cs
);

  localparam int AXW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_MUL  = 4'b0010,
    P_CORD = 4'b0100,
    P_OUT  = 4'b1000
  } ph_state_t;

  ph_state_t state_r;
  logic [1:0]         ax_r;
  logic [31:0]        prod_r;
  logic               mul_v_r;
  logic [31:0]        ph_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic [1:0]         quad_r;
  logic [4:0]         i_r;
  logic               done_r;
  bhe_pkg::cs_t       cs_r;

  logic signed [47:0] prod_nxt;
  logic signed [31:0] dx, dy, at;

  // one axis product, modulo one turn
  assign prod_nxt = $signed(k_pt[ax_r]) * $signed(key[ax_r[AXW-1:0]]);
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = bhe_pkg::atan_turn(i_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      // done pulses for the cycle after the quadrant rotation
      done_r <= (state_r == P_OUT);
      case (state_r)
        P_IDLE: begin
          if (start) begin
            ax_r    <= 2'd0;
            ph_r    <= 32'd0;
            mul_v_r <= 1'b0;
            state_r <= P_MUL;
          end
        end
        P_MUL: begin
          if (mul_v_r) ph_r <= ph_r + prod_r;
          if (ax_r < nd) begin
            prod_r  <= prod_nxt[31:0];
            mul_v_r <= 1'b1;
            ax_r    <= ax_r + 2'd1;
          end else begin
            mul_v_r <= 1'b0;
            if (!mul_v_r) begin
              x_r     <= bhe_pkg::CORDIC_GAIN;
              y_r     <= 32'sd0;
              z_r     <= $signed({2'b00, ph_r[29:0]});
              quad_r  <= ph_r[31:30];
              i_r     <= 5'd0;
              state_r <= P_CORD;
            end
          end
        end
        P_CORD: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(bhe_pkg::CORDIC_STEPS - 1)) state_r <= P_OUT;
        end
        P_OUT: begin
          // quadrant rotation
          case (quad_r)
            2'd0: begin cs_r.c <= x_r;  cs_r.s <= y_r;  end
            2'd1: begin cs_r.c <= -y_r; cs_r.s <= x_r;  end
            2'd2: begin cs_r.c <= -x_r; cs_r.s <= -y_r; end
            default: begin cs_r.c <= y_r; cs_r.s <= -x_r; end
          endcase
          state_r <= P_IDLE;
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign cs   = cs_r;

  `BHE_CHECK(a_start_idle, start |-> (state_r == P_IDLE), "phase start while busy")
  `BHE_CHECK(a_done_pulse, done_r |=> !done_r, "phase done held")
  `BHE_CHECK(a_step_bound, (state_r == P_CORD) |-> (i_r < 5'(bhe_pkg::CORDIC_STEPS)), "cordic overrun")

endmodule
`default_nettype wire

### hdl/bhe_lane.sv
// Column lane: holds one matrix column per term and its MAX_DOF (default 8) row accumulators.
// Depends on bhe_pkg.
`default_nettype none
module bhe_lane #(
  parameter int MAX_TERMS = bhe_pkg::DEF_MAX_TERMS,
  parameter int MAX_DOF   = bhe_pkg::DEF_MAX_DOF,
  parameter int LANE      = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bhe_pkg::ld_t      ld,
  input  wire bhe_pkg::mac_ctl_t mac,
  input  wire bhe_pkg::cs_t      cs,
  input  wire logic [2:0]        rd_row,
  output logic signed [63:0]     acc_re,
  output logic signed [63:0]     acc_im
);

  localparam int DEPTH = MAX_TERMS * MAX_DOF;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;

  logic [47:0] mem [DEPTH];
  logic [47:0] rd_q_r;
  logic        v1_r, v2_r;
  logic [2:0]  row1_r, row2_r;
  logic signed [55:0] p_ac_r, p_bs_r, p_bc_r, p_as_r;
  logic signed [63:0] acc_re_r [MAX_DOF];
  logic signed [63:0] acc_im_r [MAX_DOF];

  logic [31:0] waddr32, raddr32;
  logic signed [23:0] a, b;
  logic signed [63:0] add_re, add_im;
  logic [DW-1:0] sel;

  assign waddr32 = 32'(ld.term) * 32'(MAX_DOF) + 32'(ld.row);
  assign raddr32 = 32'(mac.term) * 32'(MAX_DOF) + 32'(mac.row);

  // column store
  always_ff @(posedge clk) begin
    if (ld.wr && ld.col == 3'(LANE)) mem[waddr32[AW-1:0]] <= {ld.re, ld.im};
    if (mac.issue) rd_q_r <= mem[raddr32[AW-1:0]];
    row1_r <= mac.row;
  end

  // complex products
  assign a = $signed(rd_q_r[47:24]);
  assign b = $signed(rd_q_r[23:0]);
  always_ff @(posedge clk) begin
    p_ac_r <= a * cs.c;
    p_bs_r <= b * cs.s;
    p_bc_r <= b * cs.c;
    p_as_r <= a * cs.s;
    row2_r <= row1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= mac.issue;
      v2_r <= v1_r;
    end
  end

  // accumulate, one row a cycle; single read index shared with emission
  assign add_re = 64'(p_ac_r) + 64'(p_bs_r);
  assign add_im = 64'(p_bc_r) - 64'(p_as_r);
  assign sel = v2_r ? row2_r[DW-1:0] : rd_row[DW-1:0];
  assign acc_re = acc_re_r[sel];
  assign acc_im = acc_im_r[sel];

  always_ff @(posedge clk) begin
    if (mac.clear) begin
      for (int r = 0; r < MAX_DOF; r++) begin
        acc_re_r[r] <= 64'sd0;
        acc_im_r[r] <= 64'sd0;
      end
    end else if (v2_r) begin
      acc_re_r[sel] <= acc_re + add_re;
      acc_im_r[sel] <= acc_im + add_im;
    end
  end

endmodule
`default_nettype wire

### hdl/bloch_hamiltonian_eval.sv
// Top level of the Bloch Hamiltonian evaluator: stores, sequencer, output.
// Depends on bhe_pkg, bhe_phase, bhe_lane and bloch_hamiltonian_eval_macros.svh.
//
//  channel | direction | handshake         | carries
//  in_     | request   | in_valid/in_stall | kind, term, row, col, keys, entry, k-point
//  out_    | result    | out_valid/out_stall | row, col, h_re, h_im, saturated, last
//  cfg_    | APB       | psel/penable      | terms_in_use, dims_in_use, dof_in_use
//
// For an evaluate request, per term the shared CORDIC runs 24 steps, then the
// column lanes work one row per cycle.
// Reset is synchronous; the stores hold no valid bits and need no clearing pass.
// out_stall holds emission only; input is stalled while an evaluation runs.
`default_nettype none
`include "bloch_hamiltonian_eval_macros.svh"
module bloch_hamiltonian_eval #(
  parameter int MAX_TERMS = bhe_pkg::DEF_MAX_TERMS,
  parameter int MAX_DIMS  = bhe_pkg::DEF_MAX_DIMS,
  parameter int MAX_DOF   = bhe_pkg::DEF_MAX_DOF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [5:0]         in_term,
  input  wire logic [2:0]         in_row,
  input  wire logic [2:0]         in_col,
  input  wire logic signed [15:0] in_key_x,
  input  wire logic signed [15:0] in_key_y,
  input  wire logic signed [15:0] in_key_z,
  input  wire logic signed [23:0] in_value_re,
  input  wire logic signed [23:0] in_value_im,
  input  wire logic signed [31:0] in_k_x,
  input  wire logic signed [31:0] in_k_y,
  input  wire logic signed [31:0] in_k_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [31:0]      out_h_re,
  output logic signed [31:0]      out_h_im,
  output logic                    out_saturated,
  output logic                    out_last,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [3:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int TW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int DW = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;
  localparam int TERM_W = bhe_pkg::TERM_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_KEY   = 7'b0000010,
    S_START = 7'b0000100,
    S_PHASE = 7'b0001000,
    S_MAC   = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r;
  logic [6:0] terms_r;
  logic [1:0] dims_r;
  logic [3:0] dof_r;
  logic [TERM_W-1:0] nt_r, term_r;
  logic [1:0]  nd_r;
  logic [3:0]  nf_r;
  logic [2:0]  row_r, er_r, ec_r;
  logic [1:0]  drain_r;
  logic [2:0][31:0] k_r;
  logic [MAX_DIMS*16-1:0] key_mem [MAX_TERMS];
  logic [MAX_DIMS-1:0][15:0] key_q_r, key_wr;

  logic out_valid_r, out_last_r, out_sat_r;
  logic [2:0] out_row_r, out_col_r;
  logic signed [31:0] out_re_r, out_im_r;

  logic acc_in, acc_eval, cfg_wr;
  logic term_ok, entry_ok;
  logic [TERM_W-1:0] term_ext;
  logic ph_start, ph_done;
  bhe_pkg::cs_t cs;
  bhe_pkg::ld_t ld;
  bhe_pkg::mac_ctl_t mac;
  logic signed [63:0] lane_re [MAX_DOF];
  logic signed [63:0] lane_im [MAX_DOF];

  assign acc_in   = in_valid && !in_stall;
  assign acc_eval = acc_in && (in_kind == bhe_pkg::KIND_EVAL);
  assign term_ext = TERM_W'(in_term);
  assign term_ok  = 32'(in_term) < 32'(MAX_TERMS);
  assign entry_ok = term_ok && (32'(in_row) < 32'(MAX_DOF)) && (32'(in_col) < 32'(MAX_DOF));
  assign in_stall = (state_r != S_IDLE);

  // configuration registers
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terms_r <= 7'd0;
      dims_r  <= 2'd3;
      dof_r   <= 4'd8;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        bhe_pkg::REG_TERMS: terms_r <= cfg_pwdata[6:0];
        bhe_pkg::REG_DIMS:  dims_r  <= cfg_pwdata[1:0];
        bhe_pkg::REG_DOF:   dof_r   <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      bhe_pkg::REG_TERMS: cfg_prdata = 32'(terms_r);
      bhe_pkg::REG_DIMS:  cfg_prdata = 32'(dims_r);
      bhe_pkg::REG_DOF:   cfg_prdata = 32'(dof_r);
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // key store, one row of axes per term
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      key_wr[d] = (d == 0) ? in_key_x : ((d == 1) ? in_key_y : in_key_z);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && in_kind == bhe_pkg::KIND_KEY && term_ok) key_mem[term_ext[TW-1:0]] <= key_wr;
    key_q_r <= key_mem[term_r[TW-1:0]];
  end

  // lane controls
  always_comb begin
    ld.wr   = acc_in && (in_kind == bhe_pkg::KIND_ENTRY) && entry_ok;
    ld.term = term_ext;
    ld.row  = in_row;
    ld.col  = in_col;
    ld.re   = in_value_re;
    ld.im   = in_value_im;
    mac.clear = acc_eval;
    mac.issue = (state_r == S_MAC);
    mac.term  = term_r;
    mac.row   = row_r;
  end
  assign ph_start = (state_r == S_START);

  bhe_phase #(.MAX_DIMS(MAX_DIMS)) u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ph_start),
    .k_pt  (k_r),
    .key   (key_q_r),
    .nd    (nd_r),
    .done  (ph_done),
    .cs    (cs)
  );

  for (genvar l = 0; l < MAX_DOF; l++) begin : g_lane
    bhe_lane #(.MAX_TERMS(MAX_TERMS), .MAX_DOF(MAX_DOF), .LANE(l)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ld     (ld),
      .mac    (mac),
      .cs     (cs),
      .rd_row (er_r),
      .acc_re (lane_re[l]),
      .acc_im (lane_im[l])
    );
  end

  // merge: pick the column lane, round to Q16.16 and clip
  logic signed [63:0] sel_re, sel_im, rnd_re, rnd_im;
  logic [33:0] q_re, q_im;
  logic hi_re, lo_re, hi_im, lo_im;
  logic signed [31:0] h_re_nxt, h_im_nxt;
  logic last_nxt, slot_free;

  assign sel_re = lane_re[ec_r[DW-1:0]];
  assign sel_im = lane_im[ec_r[DW-1:0]];
  assign rnd_re = sel_re + 64'sd536870912;
  assign rnd_im = sel_im + 64'sd536870912;
  assign q_re = rnd_re[63:30];
  assign q_im = rnd_im[63:30];
  assign hi_re = !q_re[33] && (q_re[32:31] != 2'b00);
  assign lo_re = q_re[33] && (q_re[32:31] != 2'b11);
  assign hi_im = !q_im[33] && (q_im[32:31] != 2'b00);
  assign lo_im = q_im[33] && (q_im[32:31] != 2'b11);
  assign h_re_nxt = hi_re ? 32'sh7FFFFFFF : (lo_re ? 32'sh80000000 : $signed(q_re[31:0]));
  assign h_im_nxt = hi_im ? 32'sh7FFFFFFF : (lo_im ? 32'sh80000000 : $signed(q_im[31:0]));
  assign last_nxt = ({1'b0, er_r} == nf_r - 4'd1) && ({1'b0, ec_r} == nf_r - 4'd1);
  assign slot_free = !out_valid_r || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the emit state reloads the output slot itself
      if (out_valid_r && !out_stall && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc_eval) begin
            k_r    <= {in_k_z, in_k_y, in_k_x};
            nt_r   <= (32'(terms_r) > 32'(MAX_TERMS)) ? TERM_W'(MAX_TERMS) : TERM_W'(terms_r);
            nd_r   <= (32'(dims_r) > 32'(MAX_DIMS)) ? 2'(MAX_DIMS) : dims_r;
            nf_r   <= (32'(dof_r) > 32'(MAX_DOF)) ? 4'(MAX_DOF) : dof_r;
            term_r <= '0;
            er_r   <= 3'd0;
            ec_r   <= 3'd0;
            if (dof_r == 4'd0) state_r <= S_IDLE;
            else if (terms_r == 7'd0) state_r <= S_EMIT;
            else state_r <= S_KEY;
          end
        end
        S_KEY:   state_r <= S_START;
        S_START: state_r <= S_PHASE;
        S_PHASE: begin
          if (ph_done) begin
            row_r   <= 3'd0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          row_r <= row_r + 3'd1;
          if ({1'b0, row_r} == nf_r - 4'd1) begin
            if (term_r == nt_r - TERM_W'(1)) begin
              drain_r <= 2'd0;
              state_r <= S_DRAIN;
            end else begin
              term_r  <= term_r + TERM_W'(1);
              state_r <= S_KEY;
            end
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 2'd1;
          if (drain_r == 2'd2) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= er_r;
            out_col_r   <= ec_r;
            out_re_r    <= h_re_nxt;
            out_im_r    <= h_im_nxt;
            out_sat_r   <= hi_re || lo_re || hi_im || lo_im;
            out_last_r  <= last_nxt;
            if (last_nxt) begin
              state_r <= S_IDLE;
            end else if ({1'b0, ec_r} == nf_r - 4'd1) begin
              ec_r <= 3'd0;
              er_r <= er_r + 3'd1;
            end else begin
              ec_r <= ec_r + 3'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_h_re      = out_re_r;
  assign out_h_im      = out_im_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

  `BHE_CHECK(a_mac_row, (state_r == S_MAC) |-> ({1'b0, row_r} < nf_r), "row beyond side")
  `BHE_CHECK(a_last_gap, (out_valid_r && out_last_r && !out_stall) |=> !out_valid_r, "result after last")
  `BHE_CHECK(a_phase_wait, ph_done |-> (state_r == S_PHASE), "phasor arrived unexpectedly")

endmodule
`default_nettype wire
